@@ hdl/trd_pkg.sv @@
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and codes for the row tuple deserializer.
// ----------------------------------------------------------------------------
package trd_pkg;

    localparam int MAX_ATTRS = 8;
    localparam int CFG_W     = 64;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_ATTR_COUNT   = 2'd0;
    localparam logic [1:0] REG_ATTR_KINDS   = 2'd1;
    localparam logic [1:0] REG_ATTR_LENGTHS = 2'd2;

    // Byte roles
    localparam logic [1:0] ROLE_BITMAP = 2'd0;
    localparam logic [1:0] ROLE_PREFIX = 2'd1;
    localparam logic [1:0] ROLE_DATA   = 2'd2;
    localparam logic [1:0] ROLE_STRAY  = 2'd3;

    // Attribute kinds (kind 3 behaves as by-reference)
    localparam logic [1:0] KIND_VALUE = 2'd0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       row_start;
        logic       has_nulls;
    } item_t;

    typedef struct packed {
        logic [1:0]         byte_role;
        logic [2:0]         attr_index;
        logic [31:0]        byte_in_attr;
        logic               attr_done;
        logic signed [63:0] scalar_value;
        logic               row_done;
        logic [7:0]         null_mask;
        logic               format_error;
    } result_t;

    typedef struct packed {
        logic        active;
        logic [2:0]  attr;
        logic [31:0] cnt;
        logic [31:0] vlen;
        logic [7:0]  present;
        logic [63:0] acc;
    } parse_state_t;

endpackage

@@ hdl/trd_step.sv @@
// ----------------------------------------------------------------------------
// trd_step
// Per-word parse step: tags one row byte and works out the next parse state.
// ----------------------------------------------------------------------------
module trd_step (
    input  trd_pkg::parse_state_t st,
    input  trd_pkg::item_t        item,
    input  logic [3:0]            attr_count,
    input  logic [15:0]           attr_kinds,
    input  logic [63:0]           attr_lengths,
    output trd_pkg::parse_state_t st_next,
    output trd_pkg::result_t      res
);
    import trd_pkg::*;

    logic [3:0]   eff_count;
    logic [7:0]   cmask;
    parse_state_t work;
    logic [1:0]   kind;
    logic [7:0]   len;
    logic [63:0]  acc_new;
    logic [31:0]  vl_new;
    logic         done;
    logic         err;
    logic [3:0]   first_bm;
    logic [3:0]   first_nx;

    // Lowest set bit of m at or above start; bit 3 of the result flags a hit
    function automatic logic [3:0] first_present(input logic [7:0] m,
                                                 input logic [3:0] start);
        logic [3:0] r;
        r = 4'd0;
        for (int i = MAX_ATTRS - 1; i >= 0; i--)
        begin
            if (m[i] && (4'(i) >= start))
            begin
                r = {1'b1, 3'(i)};
            end
        end
        return r;
    endfunction

    // Clamp the attribute count and build its mask
    always_comb
    begin
        if (attr_count == 4'd0)
        begin
            eff_count = 4'd1;
        end
        else if (attr_count > 4'(MAX_ATTRS))
        begin
            eff_count = 4'(MAX_ATTRS);
        end
        else
        begin
            eff_count = attr_count;
        end
        for (int i = 0; i < MAX_ATTRS; i++)
        begin
            cmask[i] = (4'(i) < eff_count);
        end
    end

    // Apply a row start before the byte is parsed
    always_comb
    begin
        work = st;
        if (item.row_start)
        begin
            work.present = item.has_nulls ? item.data_byte : 8'hFF;
            work.active  = 1'b1;
            work.attr    = 3'd0;
            work.cnt     = 32'd0;
            work.vlen    = 32'd0;
            work.acc     = 64'd0;
        end
    end

    assign kind     = attr_kinds[{work.attr, 1'b0} +: 2];
    assign len      = attr_lengths[{work.attr, 3'b000} +: 8];
    assign first_bm = first_present(work.present & cmask, 4'd0);
    assign first_nx = first_present(work.present & cmask, {1'b0, work.attr} + 4'd1);

    // Tag the byte and advance the parse
    always_comb
    begin
        st_next = work;
        res     = '0;
        done    = 1'b0;
        err     = 1'b0;
        acc_new = work.acc;
        vl_new  = work.vlen;

        if (item.row_start && item.has_nulls)
        begin
            res.byte_role = ROLE_BITMAP;
            if (!first_bm[3])
            begin
                st_next.active = 1'b0;
                st_next.attr   = 3'd0;
                res.row_done   = 1'b1;
                res.null_mask  = ~work.present & cmask;
            end
            else
            begin
                st_next.attr = first_bm[2:0];
            end
        end
        else if (!work.active)
        begin
            res.byte_role = ROLE_STRAY;
        end
        else
        begin
            res.attr_index   = work.attr;
            res.byte_in_attr = work.cnt;
            if (kind == KIND_VALUE)
            begin
                res.byte_role = ROLE_DATA;
                if (len != 8'd1 && len != 8'd2 && len != 8'd4 && len != 8'd8)
                begin
                    err = 1'b1;
                end
                else
                begin
                    if (work.cnt < 32'd8)
                    begin
                        acc_new = work.acc
                                | (64'(item.data_byte) << {work.cnt[2:0], 3'b000});
                    end
                    st_next.acc = acc_new;
                    if ((33'(work.cnt) + 33'd1) >= 33'(len))
                    begin
                        done = 1'b1;
                        case (len)
                            8'd1:    res.scalar_value = {{56{acc_new[7]}}, acc_new[7:0]};
                            8'd2:    res.scalar_value = {{48{acc_new[15]}}, acc_new[15:0]};
                            8'd4:    res.scalar_value = {{32{acc_new[31]}}, acc_new[31:0]};
                            default: res.scalar_value = acc_new;
                        endcase
                    end
                end
            end
            else if (len != 8'd0)
            begin
                res.byte_role = ROLE_DATA;
                done = (33'(work.cnt) + 33'd1) >= 33'(len);
            end
            else if (work.cnt < 32'd4)
            begin
                // Assemble the little-endian length prefix
                res.byte_role = ROLE_PREFIX;
                vl_new = work.vlen | (32'(item.data_byte) << {work.cnt[1:0], 3'b000});
                st_next.vlen = vl_new;
                if (work.cnt[1:0] == 2'd3)
                begin
                    if (vl_new[31])
                    begin
                        err = 1'b1;
                    end
                    else if (vl_new == 32'd0)
                    begin
                        done = 1'b1;
                    end
                end
            end
            else
            begin
                res.byte_role = ROLE_DATA;
                done = (34'(work.cnt) + 34'd1) >= (34'd4 + 34'(work.vlen));
            end

            if (err)
            begin
                res.format_error = 1'b1;
                st_next.active   = 1'b0;
            end
            else if (done)
            begin
                // Move on to the next present attribute, or close the row
                res.attr_done = 1'b1;
                st_next.cnt   = 32'd0;
                st_next.vlen  = 32'd0;
                st_next.acc   = 64'd0;
                if (!first_nx[3])
                begin
                    st_next.active = 1'b0;
                    st_next.attr   = 3'd0;
                    res.row_done   = 1'b1;
                    res.null_mask  = ~work.present & cmask;
                end
                else
                begin
                    st_next.attr = first_nx[2:0];
                end
            end
            else if (work.cnt != 32'hFFFF_FFFF)
            begin
                st_next.cnt = work.cnt + 32'd1;
            end
        end
    end

endmodule

@@ hdl/tuple_record_deserializer.sv @@
// ----------------------------------------------------------------------------
// tuple_record_deserializer
// Tags each byte of a serialized row against the schema held in registers.
// ----------------------------------------------------------------------------
// The result word for an accepted byte is registered and is shown in the following cycle.
// Throughput: one byte per cycle while result_ready keeps the output free; the parse state and the
//   result register are both updated in the accepting cycle, so the per-byte step sets the rate.
// Reset: no open row, attribute count 1, kinds and lengths zero, result empty.
module tuple_record_deserializer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  trd_pkg::item_t        item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output trd_pkg::result_t      result,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [63:0]           cfg_data
);
    import trd_pkg::*;

    logic [3:0]   attr_count_reg;
    logic [15:0]  attr_kinds_reg;
    logic [63:0]  attr_lengths_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      res_reg;
    result_t      res_next;
    logic         res_valid_reg;
    logic         accept;

    assign item_ready   = !res_valid_reg || result_ready;
    assign accept       = item_valid && item_ready;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Schema registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_count_reg   <= 4'd1;
            attr_kinds_reg   <= 16'd0;
            attr_lengths_reg <= 64'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ATTR_COUNT:   attr_count_reg   <= cfg_data[3:0];
                REG_ATTR_KINDS:   attr_kinds_reg   <= cfg_data[15:0];
                REG_ATTR_LENGTHS: attr_lengths_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    trd_step u_step (
        .st           (state_reg),
        .item         (item),
        .attr_count   (attr_count_reg),
        .attr_kinds   (attr_kinds_reg),
        .attr_lengths (attr_lengths_reg),
        .st_next      (state_next),
        .res          (res_next)
    );

    // Advance the parse state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.active  <= 1'b0;
            state_reg.attr    <= 3'd0;
            state_reg.cnt     <= 32'd0;
            state_reg.vlen    <= 32'd0;
            state_reg.present <= 8'hFF;
            state_reg.acc     <= 64'd0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result word until it is taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    // A row only closes on a bitmap byte or on the last byte of an attribute
    a_row_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.row_done |->
            result.attr_done || result.byte_role == ROLE_BITMAP)
        else $error("row closed without a completing byte");

    // A stray byte carries no attribute and closes nothing
    a_stray_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.byte_role == ROLE_STRAY |->
            result.attr_index == 3'd0 && result.byte_in_attr == 32'd0
            && !result.row_done && !result.attr_done)
        else $error("stray byte carries attribute data");

    // A format error abandons the row
    a_error_abandons: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_next.format_error |=> !state_reg.active)
        else $error("row still open after a format error");

    // An error byte never completes an attribute
    a_error_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.format_error |-> !result.attr_done && !result.row_done)
        else $error("error byte completes an attribute");

endmodule
